>>> src/cltr_pkg.sv
// ----------------------------------------------------------------------------
// Charger load throttle relay package
// Shared codes, constants and structures of the load throttle relay block.
// ----------------------------------------------------------------------------
package cltr_pkg;

  // Bay status codes. Codes 2 and 3 mean neither free nor charging.
  localparam logic [1:0] BAY_FREE     = 2'd0;
  localparam logic [1:0] BAY_CHARGING = 2'd1;

  // Throttle levels in percent and the duration limit of cap handling.
  localparam logic [6:0]  SAFETY_PCT  = 7'd50;
  localparam logic [6:0]  CAP_PCT     = 7'd70;
  localparam logic [6:0]  FULL_PCT    = 7'd100;
  localparam logic [15:0] CAP_MINUTES = 16'd10;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  typedef enum logic [1:0] {
    DEC_ALLOW      = 2'd0,
    DEC_LOW_DEMAND = 2'd1,
    DEC_STANDBY    = 2'd2,
    DEC_THROTTLE   = 2'd3
  } decision_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PEAK_START  = 3'd0,
    CFG_PEAK_END    = 3'd1,
    CFG_ARRIVAL_THR = 3'd2,
    CFG_OVERCURRENT = 3'd3,
    CFG_POWER_CAP   = 3'd4,
    CFG_DUTY_WINDOW = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]  peak_start_hour;
    logic [4:0]  peak_end_hour;
    logic [8:0]  arrival_threshold;
    logic [16:0] overcurrent_limit_ma;
    logic [17:0] station_power_cap_w;
    logic [15:0] duty_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] phase_count;
    logic [6:0]  throttle;
    logic        overload;
    decision_e   decision;
  } state_t;

  typedef struct packed {
    logic [1:0]  bay_state;
    logic [16:0] current_ma;
    logic [17:0] station_power_w;
    logic [4:0]  hour_of_day;
    logic [8:0]  arrival_prob;
    logic [15:0] expected_minutes;
    logic        manual_mode;
    logic        manual_relay_ctl;
    logic        manual_relay_on;
    logic [6:0]  manual_throttle;
  } item_t;

  typedef struct packed {
    logic        relay_on;
    decision_e   load_decision;
    logic [6:0]  throttle_pct;
    logic        overload_flag;
    logic        led_red;
    logic        led_grn;
    logic        led_ylw;
  } result_t;

endpackage

>>> src/cltr_step.sv
// ----------------------------------------------------------------------------
// Charger load throttle relay tick logic
// Combinational update of the load state and relay level for one tick.
// ----------------------------------------------------------------------------
module cltr_step (
  input  cltr_pkg::cfg_t    cfg_i,
  input  cltr_pkg::state_t  state_i,
  input  cltr_pkg::item_t   item_i,
  output cltr_pkg::state_t  state_o,
  output cltr_pkg::result_t result_o
);

  logic                charging;
  logic                bay_free;
  logic                peak;
  logic [6:0]          man_thr;
  logic [6:0]          throttle_d;
  logic                overload_d;
  cltr_pkg::decision_e decision_d;
  logic [15:0]         win;
  logic [6:0]          duty_pct;
  logic [16:0]         phase_inc;
  logic [22:0]         on_prod;
  logic [22:0]         phase_scaled;
  logic                duty_on;
  logic                relay;

  assign charging = (item_i.bay_state == cltr_pkg::BAY_CHARGING);
  assign bay_free = (item_i.bay_state == cltr_pkg::BAY_FREE);
  assign peak     = (item_i.hour_of_day >= cfg_i.peak_start_hour) &&
                    (item_i.hour_of_day <= cfg_i.peak_end_hour);
  assign man_thr  = (item_i.manual_throttle > cltr_pkg::FULL_PCT) ?
                    cltr_pkg::FULL_PCT : item_i.manual_throttle;

  always_comb begin
    decision_d = state_i.decision;
    throttle_d = state_i.throttle;
    overload_d = state_i.overload;
    if (!item_i.manual_mode) begin
      overload_d = 1'b0;
      if (!charging) begin
        if (peak && (item_i.arrival_prob >= cfg_i.arrival_threshold)) begin
          decision_d = cltr_pkg::DEC_STANDBY;
        end else if (peak) begin
          decision_d = cltr_pkg::DEC_LOW_DEMAND;
        end else begin
          decision_d = cltr_pkg::DEC_ALLOW;
        end
      end else if (item_i.current_ma > cfg_i.overcurrent_limit_ma) begin
        decision_d = cltr_pkg::DEC_THROTTLE;
        throttle_d = cltr_pkg::SAFETY_PCT;
        overload_d = 1'b1;
      end else if ((item_i.station_power_w > cfg_i.station_power_cap_w) &&
                   (item_i.expected_minutes > cltr_pkg::CAP_MINUTES)) begin
        decision_d = cltr_pkg::DEC_THROTTLE;
        throttle_d = cltr_pkg::CAP_PCT;
      end else begin
        decision_d = cltr_pkg::DEC_ALLOW;
        throttle_d = cltr_pkg::FULL_PCT;
      end
    end else begin
      throttle_d = state_i.overload ? cltr_pkg::SAFETY_PCT : man_thr;
    end
  end

  // The relay is on while phase < floor(win * pct / 100), which is the same
  // as 100 * (phase + 1) <= win * pct, so no divider is needed.
  assign win          = (cfg_i.duty_window_ms == 16'd0) ? 16'd1 : cfg_i.duty_window_ms;
  assign duty_pct     = overload_d ? cltr_pkg::SAFETY_PCT : throttle_d;
  assign phase_inc    = {1'b0, state_i.phase_count} + 17'd1;
  assign on_prod      = 23'(win) * 23'(duty_pct);
  assign phase_scaled = 23'(phase_inc) * 23'(cltr_pkg::FULL_PCT);
  assign duty_on      = (phase_scaled <= on_prod);

  always_comb begin
    if (!charging) begin
      relay = 1'b0;
    end else if (overload_d) begin
      relay = duty_on;
    end else if (item_i.manual_mode && item_i.manual_relay_ctl) begin
      relay = item_i.manual_relay_on;
    end else if (throttle_d >= cltr_pkg::FULL_PCT) begin
      relay = 1'b1;
    end else if (throttle_d == 7'd0) begin
      relay = 1'b0;
    end else begin
      relay = duty_on;
    end
  end

  always_comb begin
    state_o.decision    = decision_d;
    state_o.throttle    = throttle_d;
    state_o.overload    = overload_d;
    state_o.phase_count = (phase_inc >= {1'b0, win}) ? 16'd0 : phase_inc[15:0];

    result_o.relay_on      = relay;
    result_o.load_decision = decision_d;
    result_o.throttle_pct  = throttle_d;
    result_o.overload_flag = overload_d;
    result_o.led_red       = overload_d;
    result_o.led_grn       = bay_free && !overload_d;
    result_o.led_ylw       = charging && !overload_d;
  end

endmodule

>>> src/charger_load_throttle_relay_unit.sv
// ----------------------------------------------------------------------------
// Charger load throttle relay unit
// Per-tick load decision, throttle, overload flag, duty-cycled relay and lamps.
// ----------------------------------------------------------------------------
// Each accepted item is one millisecond tick and yields exactly one result
// item. The decision, the throttle update and the
// relay duty compare (one 16 by 7 bit multiply against the phase scaled by
// 100) are done in the cycle of acceptance and land in the result register,
// so the block takes a new item in every cycle while the output is not
// stalled. A two-entry output stage (result register plus skid register)
// lets one more item in while a result waits; in_stall_o rises only when
// both entries are full. The load state and the relay phase counter advance
// at acceptance. Configuration registers take effect on the next item and
// are meant to be written only while no result is pending; cfg_ready_o is
// always high.
// ----------------------------------------------------------------------------
module charger_load_throttle_relay_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cltr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cltr_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    bay_state_i,
  input  logic [16:0]                   current_ma_i,
  input  logic [17:0]                   station_power_w_i,
  input  logic [4:0]                    hour_of_day_i,
  input  logic [8:0]                    arrival_prob_i,
  input  logic [15:0]                   expected_minutes_i,
  input  logic                          manual_mode_i,
  input  logic                          manual_relay_ctl_i,
  input  logic                          manual_relay_on_i,
  input  logic [6:0]                    manual_throttle_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          relay_on_o,
  output logic [1:0]                    load_decision_o,
  output logic [6:0]                    throttle_pct_o,
  output logic                          overload_flag_o,
  output logic                          led_red_o,
  output logic                          led_grn_o,
  output logic                          led_ylw_o
);

  cltr_pkg::cfg_t    cfg_q;
  cltr_pkg::state_t  state_q;
  cltr_pkg::state_t  state_d;
  cltr_pkg::item_t   item;
  cltr_pkg::result_t result_d;
  cltr_pkg::result_t out_q;
  cltr_pkg::result_t skid_q;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              skid_valid_q;
  logic              skid_valid_d;
  logic              in_accept;
  logic              out_free;
  logic              out_load;
  logic              skid_load;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to indexes past the list are dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_start_hour      <= 5'd17;
      cfg_q.peak_end_hour        <= 5'd21;
      cfg_q.arrival_threshold    <= 9'd179;
      cfg_q.overcurrent_limit_ma <= 17'd32000;
      cfg_q.station_power_cap_w  <= 18'd22000;
      cfg_q.duty_window_ms       <= 16'd10000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cltr_pkg::CFG_PEAK_START:  cfg_q.peak_start_hour      <= cfg_data_i[4:0];
        cltr_pkg::CFG_PEAK_END:    cfg_q.peak_end_hour        <= cfg_data_i[4:0];
        cltr_pkg::CFG_ARRIVAL_THR: cfg_q.arrival_threshold    <= cfg_data_i[8:0];
        cltr_pkg::CFG_OVERCURRENT: cfg_q.overcurrent_limit_ma <= cfg_data_i[16:0];
        cltr_pkg::CFG_POWER_CAP:   cfg_q.station_power_cap_w  <= cfg_data_i[17:0];
        cltr_pkg::CFG_DUTY_WINDOW: cfg_q.duty_window_ms       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tick logic: next load state and the result of the item at the inputs.
  // --------------------------------------------------------------------------
  assign item.bay_state        = bay_state_i;
  assign item.current_ma       = current_ma_i;
  assign item.station_power_w  = station_power_w_i;
  assign item.hour_of_day      = hour_of_day_i;
  assign item.arrival_prob     = arrival_prob_i;
  assign item.expected_minutes = expected_minutes_i;
  assign item.manual_mode      = manual_mode_i;
  assign item.manual_relay_ctl = manual_relay_ctl_i;
  assign item.manual_relay_on  = manual_relay_on_i;
  assign item.manual_throttle  = manual_throttle_i;

  cltr_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item),
    .state_o (state_d),
    .result_o(result_d)
  );

  // The state only moves when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase_count <= 16'd0;
      state_q.throttle    <= cltr_pkg::FULL_PCT;
      state_q.overload    <= 1'b0;
      state_q.decision    <= cltr_pkg::DEC_ALLOW;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage. The result register feeds the port; the skid register
  // catches one item accepted while the result register is stalled.
  // --------------------------------------------------------------------------
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    if (out_free) begin
      // When the skid holds an item no new item was accepted this cycle.
      out_valid_d  = skid_valid_q || in_accept;
      out_load     = skid_valid_q || in_accept;
      skid_valid_d = 1'b0;
    end else if (in_accept) begin
      skid_valid_d = 1'b1;
      skid_load    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : result_d;
    end
    if (skid_load) begin
      skid_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign relay_on_o      = out_q.relay_on;
  assign load_decision_o = out_q.load_decision;
  assign throttle_pct_o  = out_q.throttle_pct;
  assign overload_flag_o = out_q.overload_flag;
  assign led_red_o       = out_q.led_red;
  assign led_grn_o       = out_q.led_grn;
  assign led_ylw_o       = out_q.led_ylw;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The skid register is only filled behind a waiting result.
  a_skid_behind_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q
  ) else $error("skid register holds an item while the result register is empty");

  // A held overload always comes with the safety throttle level.
  a_overload_throttle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q.overload |-> (state_q.throttle == cltr_pkg::SAFETY_PCT)
  ) else $error("overload held without the safety throttle level");

  // Each accepted tick advances the phase by one or wraps it to zero.
  a_phase_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> ((state_q.phase_count == 16'd0) ||
                   ({1'b0, state_q.phase_count} ==
                    {1'b0, $past(state_q.phase_count)} + 17'd1))
  ) else $error("phase counter moved by other than one tick");

  // Without an accepted item the load state stays put.
  a_state_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q)
  ) else $error("load state changed without an accepted item");

endmodule
